// ===== design/bcc_pkg.sv =====
// Package for the button click classifier: widths, reset values, register indexes, event codes.
package bcc_pkg;

	localparam int TimeWidthDefault = 16;
	localparam int CfgW = 16;
	localparam int CfgIdxW = 2;
	localparam int MinClickHold = 50;
	localparam int TripleCount = 3;

	localparam logic [CfgW-1:0] DebounceReset = 16'd50;
	localparam logic [CfgW-1:0] LongPressReset = 16'd1000;
	localparam logic [CfgW-1:0] ClickTimeoutReset = 16'd300;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ACTIVE_LOW = 2'd0,
		REG_DEBOUNCE = 2'd1,
		REG_LONG_PRESS = 2'd2,
		REG_CLICK_TIMEOUT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_SINGLE = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_TRIPLE = 3'd3,
		EV_LONG = 3'd4
	} event_t;

endpackage

// ===== design/button_click_classifier_unit.sv =====
// The result word of an accepted input word is loaded into the output register in the cycle after it is taken.
// Throughput: one word per cycle; the input is taken whenever the output register is empty
// or its word is taken in the same cycle.
// Reset (arst_n low, asynchronous): state counters clear, button released, no result pending,
// registers return to active_low 1, debounce 50, long press 1000, click timeout 300.
// Top level of the button click classifier.
module button_click_classifier_unit
	import bcc_pkg::*;
#(
	parameter int TIME_WIDTH = TimeWidthDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [0] raw_level, [7:1] zero
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [2:0] event_code, [3] pressed, [7:4] zero
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0] cfg_data
);

	localparam int CmpW = (TIME_WIDTH > CfgW) ? TIME_WIDTH : CfgW;
	localparam logic [TIME_WIDTH-1:0] TimeMax = '1;

	logic active_low_q;
	logic [CfgW-1:0] debounce_q, long_press_q, click_timeout_q;

	logic prev_level_q;
	logic [TIME_WIDTH-1:0] stable_q, hold_q, since_q;
	logic pressed_q;
	logic [1:0] tally_q;
	logic pending_q;

	logic out_valid_q;
	event_t out_event_q;
	logic out_pressed_q;

	logic accept;
	logic level, raw_pressed, edge_ok;
	logic [TIME_WIDTH-1:0] stable_n, hold_n, since_n;
	logic pressed_n, pending_n;
	logic [1:0] tally_n;
	event_t ev_n;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {4'b0000, out_pressed_q, out_event_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_low_q <= 1'b1;
			debounce_q <= DebounceReset;
			long_press_q <= LongPressReset;
			click_timeout_q <= ClickTimeoutReset;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACTIVE_LOW: active_low_q <= cfg_data[0];
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_CLICK_TIMEOUT: click_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		level = s_axis_tdata[0];
		raw_pressed = level ^ active_low_q;
		ev_n = EV_NONE;
		if (level != prev_level_q)
			stable_n = '0;
		else
			stable_n = (stable_q == TimeMax) ? stable_q : stable_q + 1'b1;
		hold_n = hold_q;
		if (pressed_q && hold_q != TimeMax)
			hold_n = hold_q + 1'b1;
		since_n = (since_q == TimeMax) ? since_q : since_q + 1'b1;
		pressed_n = pressed_q;
		tally_n = tally_q;
		pending_n = pending_q;
		edge_ok = (CmpW'(stable_n) > CmpW'(debounce_q)) && (raw_pressed != pressed_q);
		if (edge_ok) begin
			pressed_n = raw_pressed;
			if (raw_pressed) begin
				hold_n = '0;
			end else if (CmpW'(hold_n) >= CmpW'(long_press_q)) begin
				ev_n = EV_LONG;
				tally_n = '0;
				pending_n = 1'b0;
			end else if (CmpW'(hold_n) > CmpW'(MinClickHold)) begin
				tally_n = tally_q + 2'd1;
				since_n = '0;
				pending_n = 1'b1;
				if (tally_n == 2'(TripleCount)) begin
					ev_n = EV_TRIPLE;
					tally_n = '0;
					pending_n = 1'b0;
				end
			end
		end
		if (pending_n && !pressed_n && CmpW'(since_n) > CmpW'(click_timeout_q)) begin
			if (tally_n == 2'd1)
				ev_n = EV_SINGLE;
			else if (tally_n == 2'd2)
				ev_n = EV_DOUBLE;
			tally_n = '0;
			pending_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			stable_q <= '0;
			hold_q <= '0;
			since_q <= '0;
			pressed_q <= 1'b0;
			tally_q <= '0;
			pending_q <= 1'b0;
		end else if (accept) begin
			prev_level_q <= level;
			stable_q <= stable_n;
			hold_q <= hold_n;
			since_q <= since_n;
			pressed_q <= pressed_n;
			tally_q <= tally_n;
			pending_q <= pending_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_event_q <= ev_n;
			out_pressed_q <= pressed_n;
		end
	end

endmodule

// ===== design/bcc_checker.sv =====
// Port-level checker for the button click classifier, bound to the top level.
module bcc_checker
	import bcc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [7:0] m_axis_tdata
);

	// every event is reported on a released button
	a_event_released: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] != EV_NONE |-> !m_axis_tdata[3])
		else $error("event reported while pressed");

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= EV_LONG && m_axis_tdata[7:4] == 4'd0)
		else $error("bad event code or padding");

	// an empty output register never blocks the input
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_accept_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted word produced no result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output word changed");

endmodule

bind button_click_classifier_unit bcc_checker u_bcc_checker (.*);
